[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, sizes and codes of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int CELL_W  = 16;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] SPACE_CODE   = 8'h20;
	localparam logic [7:0] RESET_COLOR  = 8'h07;

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_WRITE = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_RESULT
	} state_t;

	// Linear cell address of a row and column.
	function automatic addr_t cell_addr(input logic [4:0] row, input logic [6:0] col);
		cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
	endfunction

endpackage

[src/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[src/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode screen store with cursor, put, clear, read and write actions.
// ----------------------------------------------------------------------------
// Steps: put and write pass through EXEC and then RESULT; a read of an in-range
// cell adds READ between them. A put that scrolls adds SCROLL, a one-cell-per-cycle
// copy up through the single RAM write port, then FILL of the bottom row; clear adds
// FILL of every cell. s_tready is high only in idle, so a new word is taken only
// once the previous result is in the output register. After reset a clearing pass
// fills the screen with spaces in color 7; cfg writes are accepted throughout.
// ----------------------------------------------------------------------------
module text_console_writer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // char_code[7:0], cell_row[12:8], cell_col[19:13],
	                              // cell_color[27:20], zero[31:28]
	input  logic [1:0]  s_tuser,  // action[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // cell_entry[15:0], cursor_row[20:16],
	                              // cursor_col[27:21], scrolled[28],
	                              // bad_position[29], zero[31:30]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	localparam tcw_pkg::addr_t LAST_ADDR  = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
	localparam tcw_pkg::addr_t SCROLL_END =
		tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);

	tcw_pkg::state_t  state_q, state_d;
	tcw_pkg::addr_t   cnt_q;
	logic             cp_valid_s1;
	tcw_pkg::addr_t   cp_addr_s1;
	logic [4:0]       cur_row_q;
	logic [6:0]       cur_col_q;
	logic [7:0]       text_color_q;
	tcw_pkg::action_t act_q;
	logic [7:0]       char_q;
	logic [4:0]       row_q;
	logic [6:0]       col_q;
	logic [7:0]       color_q;
	logic [15:0]      entry_q;
	logic             scrolled_q;
	logic             bad_q;
	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;

	logic                          ram_we;
	tcw_pkg::addr_t                ram_waddr;
	logic [tcw_pkg::CELL_W-1:0]    ram_wdata;
	tcw_pkg::addr_t                ram_raddr;
	logic [tcw_pkg::CELL_W-1:0]    ram_rdata;

	logic           in_range;
	tcw_pkg::addr_t pos_addr;
	tcw_pkg::addr_t cur_addr;
	logic           is_newline;
	logic           wrap;
	logic           last_row;

	assign in_range   = (int'(row_q) < tcw_pkg::ROWS) && (int'(col_q) < tcw_pkg::COLUMNS);
	assign pos_addr   = tcw_pkg::cell_addr(row_q, col_q);
	assign cur_addr   = tcw_pkg::cell_addr(cur_row_q, cur_col_q);
	assign is_newline = (char_q == tcw_pkg::NEWLINE_CODE);
	assign wrap       = is_newline || (int'(cur_col_q) == tcw_pkg::COLUMNS - 1);
	assign last_row   = (int'(cur_row_q) == tcw_pkg::ROWS - 1);

	assign s_tready  = (state_q == tcw_pkg::ST_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign cfg_ready = 1'b1;

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(tcw_pkg::CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Sequencer: next state and RAM port control
	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = cp_addr_s1;
		ram_wdata = ram_rdata;
		ram_raddr = pos_addr;
		case (state_q)
			tcw_pkg::ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = {tcw_pkg::RESET_COLOR, tcw_pkg::SPACE_CODE};
				if (cnt_q == LAST_ADDR) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = tcw_pkg::ST_EXEC;
				end
			end
			tcw_pkg::ST_EXEC: begin
				case (act_q)
					tcw_pkg::ACT_PUT: begin
						ram_we    = !is_newline;
						ram_waddr = cur_addr;
						ram_wdata = {text_color_q, char_q};
						state_d   = (wrap && last_row) ? tcw_pkg::ST_SCROLL
						                               : tcw_pkg::ST_RESULT;
					end
					tcw_pkg::ACT_CLEAR: begin
						state_d = tcw_pkg::ST_FILL;
					end
					tcw_pkg::ACT_READ: begin
						ram_raddr = pos_addr;
						state_d   = in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_RESULT;
					end
					tcw_pkg::ACT_WRITE: begin
						ram_we    = in_range;
						ram_waddr = pos_addr;
						ram_wdata = {color_q, char_q};
						state_d   = tcw_pkg::ST_RESULT;
					end
					default: begin
						state_d = tcw_pkg::ST_RESULT;
					end
				endcase
			end
			tcw_pkg::ST_READ: begin
				state_d = tcw_pkg::ST_RESULT;
			end
			tcw_pkg::ST_SCROLL: begin
				// read one row below, write the cell fetched last cycle
				ram_raddr = cnt_q + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS);
				ram_we    = cp_valid_s1;
				ram_waddr = cp_addr_s1;
				ram_wdata = ram_rdata;
				if (cnt_q == SCROLL_END) begin
					state_d = tcw_pkg::ST_FILL;
				end
			end
			tcw_pkg::ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = {text_color_q, tcw_pkg::SPACE_CODE};
				if (cnt_q == LAST_ADDR) begin
					state_d = tcw_pkg::ST_RESULT;
				end
			end
			tcw_pkg::ST_RESULT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= tcw_pkg::RESET_COLOR;
		end else if (cfg_valid && cfg_ready) begin
			text_color_q <= cfg_data;
		end
	end

	// Control: sweep counter, copy stage, cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cp_valid_s1 <= 1'b0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			scrolled_q  <= 1'b0;
			bad_q       <= 1'b0;
		end else begin
			cp_valid_s1 <= (state_q == tcw_pkg::ST_SCROLL) && (cnt_q != SCROLL_END);
			case (state_q)
				tcw_pkg::ST_INIT, tcw_pkg::ST_FILL: begin
					if (cnt_q != LAST_ADDR) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				tcw_pkg::ST_IDLE: begin
					if (s_tvalid) begin
						scrolled_q <= 1'b0;
						bad_q      <= 1'b0;
					end
				end
				tcw_pkg::ST_EXEC: begin
					cnt_q <= '0;
					case (act_q)
						tcw_pkg::ACT_PUT: begin
							if (wrap) begin
								cur_col_q <= '0;
								if (last_row) begin
									scrolled_q <= 1'b1;
								end else begin
									cur_row_q <= cur_row_q + 1'b1;
								end
							end else begin
								cur_col_q <= cur_col_q + 1'b1;
							end
						end
						tcw_pkg::ACT_CLEAR: begin
							cur_row_q <= '0;
							cur_col_q <= '0;
						end
						tcw_pkg::ACT_READ, tcw_pkg::ACT_WRITE: begin
							bad_q <= !in_range;
						end
						default: begin
							bad_q <= 1'b0;
						end
					endcase
				end
				tcw_pkg::ST_SCROLL: begin
					// hold at the end: the fill of the bottom row starts there
					if (cnt_q != SCROLL_END) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
		if (state_q == tcw_pkg::ST_IDLE && s_tvalid) begin
			act_q   <= tcw_pkg::action_t'(s_tuser);
			char_q  <= s_tdata[7:0];
			row_q   <= s_tdata[12:8];
			col_q   <= s_tdata[19:13];
			color_q <= s_tdata[27:20];
			entry_q <= '0;
		end else if (state_q == tcw_pkg::ST_READ) begin
			entry_q <= ram_rdata;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (state_q == tcw_pkg::ST_RESULT && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {2'b00, bad_q, scrolled_q, cur_col_q, cur_row_q, entry_q};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule
